### hdl/psi_pkg.sv
package psi_pkg;

	localparam int SYM_W       = 16;
	localparam int COEF_W      = 18;
	localparam int OUT_W       = 24;
	localparam int ACT_W       = 2;
	localparam int CIDX_W      = 9;
	localparam int SP_W        = 7;
	localparam int MIN_PERIOD  = 16;
	localparam int ROUND_SHIFT = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 7;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 48;

	// A tap of exactly 1.0 in Q1.16, used to pass a held symbol through the MAC unchanged.
	localparam logic signed [COEF_W-1:0] UNITY_TAP = 18'sd65536;

	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD  = 2'd0,
		ACT_PUSH  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYMBOL_PERIOD = 1'b0,
		REG_SHAPING_MODE  = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAIT,
		ST_ISSUE,
		ST_DRAIN
	} seq_state_t;

	typedef struct packed {
		logic vld;
		logic first;
		logic last_term;
		logic eos;
		logic unity;
	} mac_ctrl_t;

	typedef struct packed {
		logic done;
		logic eos;
	} mac_res_t;

endpackage

### hdl/pulse_shaping_interpolator_core.sv
// Pulse-shaping interpolator. Input beats on s_* carry one item each: load a
// pulse tap, push a complex symbol, or clear the seven-symbol history. Loads
// and clears produce nothing. A push produces P output beats on m_*, with P
// the symbol_period register clamped to [16, MAX_SYMBOL_PERIOD]; m_tlast
// marks the last beat of the symbol.
// One multiply-accumulate unit (a pair of 16x18 multipliers) computes every
// sample, one term per cycle: T terms per sample, T = SPAN_SYMBOLS + 1 for the
// first phase and SPAN_SYMBOLS for the others in shaped mode, T = 1 in hold
// mode. The sequencer waits for the MAC to finish each sample before it
// starts the next. s_tready stays low until the last sample is in the output
// register. If the receiver stalls, the held sample stays on m_tdata and the
// next sample is not started until that beat is taken.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// do so only while idle, which the block itself does not enforce.
// Reset clears the history and sets symbol_period to 16 and shaping mode on.
// Taps are undefined after reset and must be loaded before they are used.
module pulse_shaping_interpolator_core
	import psi_pkg::*;
#(
	parameter int MAX_SYMBOL_PERIOD = 64,
	parameter int SPAN_SYMBOLS      = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// action[1:0], coef_index[10:2], coef_value[28:11], sym_re[44:29], sym_im[60:45]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// out_re[23:0], out_im[47:24]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int TAP_DEPTH  = SPAN_SYMBOLS * MAX_SYMBOL_PERIOD + 1;
	localparam int HIST_DEPTH = SPAN_SYMBOLS + 1;
	localparam int AW         = $clog2(TAP_DEPTH);
	localparam int PW         = $clog2(MAX_SYMBOL_PERIOD + 1);
	localparam int PCW        = $clog2(MAX_SYMBOL_PERIOD);

	logic [SP_W-1:0]          symbol_period_q;
	logic                     shaping_mode_q;
	logic [PW-1:0]            period;
	logic                     out_free;
	logic                     m_tvalid_q, m_tlast_q;
	logic signed [OUT_W-1:0]  out_re_q, out_im_q;
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr, ram_raddr;
	logic signed [COEF_W-1:0] ram_wdata, ram_rdata_q;
	mac_ctrl_t                term;
	logic signed [SYM_W-1:0]  term_re, term_im;
	mac_res_t                 res;
	logic signed [OUT_W-1:0]  res_re, res_im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_period_q <= SP_W'(MIN_PERIOD);
			shaping_mode_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SYMBOL_PERIOD: symbol_period_q <= cfg_data[SP_W-1:0];
				REG_SHAPING_MODE:  shaping_mode_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (32'(symbol_period_q) < 32'(MIN_PERIOD)) begin
			period = PW'(MIN_PERIOD);
		end else if (32'(symbol_period_q) > 32'(MAX_SYMBOL_PERIOD)) begin
			period = PW'(MAX_SYMBOL_PERIOD);
		end else begin
			period = PW'(symbol_period_q);
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	psi_seq #(
		.SPAN_SYMBOLS (SPAN_SYMBOLS),
		.TAP_DEPTH    (TAP_DEPTH),
		.AW           (AW),
		.PW           (PW),
		.PCW          (PCW)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.action       (action_t'(s_tdata[1:0])),
		.coef_index   (s_tdata[10:2]),
		.coef_value   (s_tdata[28:11]),
		.sym_re       (s_tdata[44:29]),
		.sym_im       (s_tdata[60:45]),
		.period       (period),
		.shaping_mode (shaping_mode_q),
		.out_free     (out_free),
		.mac_done     (res.done),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_raddr    (ram_raddr),
		.term         (term),
		.term_re      (term_re),
		.term_im      (term_im)
	);

	psi_tap_ram #(
		.DEPTH   (TAP_DEPTH),
		.AW      (AW)
	) u_tap_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr   (ram_raddr),
		.rdata_q (ram_rdata_q)
	);

	psi_mac #(
		.HIST_DEPTH (HIST_DEPTH)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.term       (term),
		.term_re    (term_re),
		.term_im    (term_im),
		.tap        (ram_rdata_q),
		.res        (res),
		.res_re     (res_re),
		.res_im     (res_im)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			out_re_q  <= res_re;
			out_im_q  <= res_im;
			m_tlast_q <= res.eos;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_im_q, out_re_q};
	assign m_tlast  = m_tlast_q;

`ifndef SYNTH
	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> !m_tvalid_q)
		else $error("sample finished while the output register still held a beat");

	a_busy_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tdata[1:0] == ACT_PUSH) |=> !s_tready)
		else $error("input accepted while a symbol is being expanded");
`endif

endmodule

### hdl/psi_tap_ram.sv
module psi_tap_ram
	import psi_pkg::*;
#(
	parameter int DEPTH = 385,
	parameter int AW    = 9
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic signed [COEF_W-1:0] wdata,
	input  logic [AW-1:0]            raddr,
	output logic signed [COEF_W-1:0] rdata_q
);

	logic signed [COEF_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

endmodule

### hdl/psi_mac.sv
module psi_mac
	import psi_pkg::*;
#(
	parameter int HIST_DEPTH = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mac_ctrl_t                term,
	input  logic signed [SYM_W-1:0]  term_re,
	input  logic signed [SYM_W-1:0]  term_im,
	input  logic signed [COEF_W-1:0] tap,
	output mac_res_t                 res,
	output logic signed [OUT_W-1:0]  res_re,
	output logic signed [OUT_W-1:0]  res_im
);

	localparam int PROD_W = SYM_W + COEF_W;
	localparam int SUM_W  = PROD_W + $clog2(HIST_DEPTH) + 1;
	localparam int SAT_W  = OUT_W + ROUND_SHIFT + 1;
	localparam int ACC_W  = (SUM_W > SAT_W) ? SUM_W : SAT_W;
	localparam int SH_W   = ACC_W - ROUND_SHIFT;
	localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) << (ROUND_SHIFT - 1);

	mac_ctrl_t                 ctrl_s1, ctrl_s2, ctrl_s3;
	logic signed [SYM_W-1:0]   re_s1, im_s1;
	logic signed [COEF_W-1:0]  tap_eff;
	logic signed [PROD_W-1:0]  prod_re_s2, prod_im_s2;
	logic signed [ACC_W-1:0]   acc_re_q, acc_im_q;

	function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] r;
		logic [SH_W-1:0]         s;
		logic [SH_W-OUT_W:0]     hi;
		r  = a + RND_BIAS;
		s  = r[ACC_W-1:ROUND_SHIFT];
		hi = s[SH_W-1:OUT_W-1];
		if (!s[SH_W-1] && (|hi)) begin
			round_sat = {1'b0, {(OUT_W-1){1'b1}}};
		end else if (s[SH_W-1] && !(&hi)) begin
			round_sat = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			round_sat = s[OUT_W-1:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else begin
			ctrl_s1 <= term;
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
		end
	end

	// The tap read issued with the term comes back from the RAM alongside stage 1.
	assign tap_eff = ctrl_s1.unity ? UNITY_TAP : tap;

	always_ff @(posedge clk) begin
		re_s1      <= term_re;
		im_s1      <= term_im;
		prod_re_s2 <= PROD_W'(re_s1) * PROD_W'(tap_eff);
		prod_im_s2 <= PROD_W'(im_s1) * PROD_W'(tap_eff);
		if (ctrl_s2.vld) begin
			if (ctrl_s2.first) begin
				acc_re_q <= ACC_W'(prod_re_s2);
				acc_im_q <= ACC_W'(prod_im_s2);
			end else begin
				acc_re_q <= acc_re_q + ACC_W'(prod_re_s2);
				acc_im_q <= acc_im_q + ACC_W'(prod_im_s2);
			end
		end
	end

	assign res.done = ctrl_s3.vld && ctrl_s3.last_term;
	assign res.eos  = ctrl_s3.eos;
	assign res_re   = round_sat(acc_re_q);
	assign res_im   = round_sat(acc_im_q);

endmodule

### hdl/psi_seq.sv
module psi_seq
	import psi_pkg::*;
#(
	parameter int SPAN_SYMBOLS = 6,
	parameter int TAP_DEPTH    = 385,
	parameter int AW           = 9,
	parameter int PW           = 7,
	parameter int PCW          = 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  action_t                  action,
	input  logic [CIDX_W-1:0]        coef_index,
	input  logic signed [COEF_W-1:0] coef_value,
	input  logic signed [SYM_W-1:0]  sym_re,
	input  logic signed [SYM_W-1:0]  sym_im,
	input  logic [PW-1:0]            period,
	input  logic                     shaping_mode,
	input  logic                     out_free,
	input  logic                     mac_done,
	output logic                     ram_we,
	output logic [AW-1:0]            ram_waddr,
	output logic signed [COEF_W-1:0] ram_wdata,
	output logic [AW-1:0]            ram_raddr,
	output mac_ctrl_t                term,
	output logic signed [SYM_W-1:0]  term_re,
	output logic signed [SYM_W-1:0]  term_im
);

	localparam int HIST_DEPTH = SPAN_SYMBOLS + 1;
	localparam int JW         = $clog2(HIST_DEPTH);

	seq_state_t              state_q, state_d;
	logic [PCW-1:0]          p_q;
	logic [JW-1:0]           j_q;
	logic [AW-1:0]           k_q;
	logic signed [SYM_W-1:0] hist_re_q [HIST_DEPTH];
	logic signed [SYM_W-1:0] hist_im_q [HIST_DEPTH];
	logic                    hist_push, hist_clear;
	logic                    p_last;
	logic [JW-1:0]           j_last;
	logic                    idx_ok;

	assign p_last    = (PW'(p_q) == (period - PW'(1)));
	// Only the first phase reaches the final tap of the pulse.
	assign j_last    = (p_q == '0) ? JW'(SPAN_SYMBOLS) : JW'(SPAN_SYMBOLS - 1);
	assign idx_ok    = (32'(coef_index) < 32'(TAP_DEPTH));
	assign ram_waddr = AW'(coef_index);
	assign ram_wdata = coef_value;
	assign ram_raddr = k_q;
	assign term_re   = hist_re_q[j_q];
	assign term_im   = hist_im_q[j_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		ram_we     = 1'b0;
		hist_push  = 1'b0;
		hist_clear = 1'b0;
		term       = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (action)
						ACT_LOAD: begin
							ram_we = idx_ok;
						end
						ACT_PUSH: begin
							hist_push = 1'b1;
							state_d   = ST_WAIT;
						end
						ACT_CLEAR: begin
							hist_clear = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_WAIT: begin
				if (out_free) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				term.vld       = 1'b1;
				term.first     = (j_q == '0);
				term.unity     = !shaping_mode;
				term.last_term = !shaping_mode || (j_q == j_last);
				term.eos       = p_last;
				if (term.last_term) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (mac_done) begin
					state_d = p_last ? ST_IDLE : ST_WAIT;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (state_q == ST_IDLE) begin
			p_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (state_q == ST_ISSUE) begin
			j_q <= j_q + JW'(1);
			k_q <= k_q + AW'(period);
		end else if (state_q == ST_DRAIN && mac_done) begin
			p_q <= p_q + PCW'(1);
			j_q <= '0;
			k_q <= AW'(p_q) + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_re_q[i] <= '0;
				hist_im_q[i] <= '0;
			end
		end else if (hist_clear) begin
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_re_q[i] <= '0;
				hist_im_q[i] <= '0;
			end
		end else if (hist_push) begin
			for (int i = HIST_DEPTH - 1; i > 0; i--) begin
				hist_re_q[i] <= hist_re_q[i-1];
				hist_im_q[i] <= hist_im_q[i-1];
			end
			hist_re_q[0] <= sym_re;
			hist_im_q[0] <= sym_im;
		end
	end

`ifndef SYNTH
	a_phase_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ISSUE |-> PW'(p_q) < period)
		else $error("phase counter ran past the symbol period");

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == ST_DRAIN)
		else $error("MAC finished a sample the sequencer was not waiting for");
`endif

endmodule
